[src/sorted_stack_binary_search_defines.svh]
// Assertion macros used by the sorted stack search sequencer
`ifndef SORTED_STACK_BINARY_SEARCH_DEFINES_SVH
`define SORTED_STACK_BINARY_SEARCH_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define SSS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define SSS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define SSS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sss_pkg.sv]
// Types and constants shared by the sorted stack search block
`timescale 1ns / 1ps

package sss_pkg;

  localparam int unsigned ValW     = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatW    = 2;
  localparam int unsigned PosW     = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutPadW  = OutDataW - (1 + PosW + CountW);

  // Command codes carried on the input tuser
  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  // Result status codes carried on the output tuser
  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // One result beat as handed from the sequencer to the output stage
  typedef struct packed {
    status_e             status;
    logic                found;
    logic [PosW-1:0]     position;
    logic [CountW-1:0]   item_count;
  } res_t;

endpackage

[src/sss_mem.sv]
// Single-port-write, single-port-read value store with registered read data
`timescale 1ns / 1ps

module sss_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/sss_seq.sv]
// Command sequencer: stack count, push/pop writes and the binary search walk
`timescale 1ns / 1ps
`include "sorted_stack_binary_search_defines.svh"

module sss_seq
  import sss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256,
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic signed [ValW-1:0] operand_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [ValW-1:0]     mem_wdata_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  logic [ValW-1:0]     mem_rdata_i
);

  localparam int unsigned SW  = CW + 1;
  localparam int unsigned CXW = (CW > CountW) ? CW : CountW;
  localparam int unsigned PXW = (CW > PosW) ? CW : PosW;
  localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);
  localparam logic signed [SW-1:0] OneS = SW'(1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSrch = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic signed [SW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]          mid_q, mid_d;
  logic signed [ValW-1:0] key_q, key_d;
  status_e                stat_q, stat_d;
  logic                   found_q, found_d;
  logic [PosW-1:0]        pos_q, pos_d;

  logic                   accept;
  logic [CW-1:0]          cnt_m1, init_mid;
  logic signed [ValW-1:0] rd_val;
  logic                   hit, go_up;
  logic signed [SW-1:0]   mid_s, a_lo, b_hi;
  logic [SW-1:0]          a_sum, b_sum;
  logic [CW-1:0]          a_mid, b_mid;
  logic                   a_cont, b_cont;
  logic [PXW-1:0]         pos_ext;
  logic [CXW-1:0]         cnt_ext;

  assign cmd_ready_o = (state_q == StIdle);
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign cnt_m1      = count_q - CW'(1);
  assign init_mid    = cnt_m1 >> 1;

  // probe compare; the entry at position mid sits at slot count-1-mid
  assign rd_val = $signed(mem_rdata_i);
  assign hit    = (rd_val == key_q);
  assign go_up  = (rd_val < key_q);

  // both possible next windows, worked out ahead of the compare
  assign mid_s  = $signed({1'b0, mid_q});
  assign a_lo   = mid_s + OneS;
  assign b_hi   = mid_s - OneS;
  assign a_sum  = {1'b0, a_lo[CW-1:0]} + {1'b0, hi_q[CW-1:0]};
  assign b_sum  = {1'b0, lo_q[CW-1:0]} + {1'b0, b_hi[CW-1:0]};
  assign a_mid  = a_sum[CW:1];
  assign b_mid  = b_sum[CW:1];
  assign a_cont = (a_lo <= hi_q);
  assign b_cont = (lo_q <= b_hi);

  assign pos_ext = PXW'(mid_q);
  assign cnt_ext = CXW'(count_q);

  // next-state logic and memory port control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    stat_d      = stat_q;
    found_d     = found_q;
    pos_d       = pos_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[AW-1:0];
    mem_wdata_o = operand_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = AW'(cnt_m1 - init_mid);

    case (state_q)
      StIdle: begin
        if (accept) begin
          stat_d  = STAT_OK;
          found_d = 1'b0;
          pos_d   = '0;
          state_d = StDone;
          case (cmd_i)
            CMD_PUSH: begin
              if (count_q < DepthC) begin
                mem_we_o = 1'b1;
                count_d  = count_q + CW'(1);
              end else begin
                stat_d = STAT_FULL;
              end
            end
            CMD_POP: begin
              if (count_q != '0) begin
                count_d = cnt_m1;
              end else begin
                stat_d = STAT_EMPTY;
              end
            end
            CMD_SEARCH: begin
              if (count_q != '0) begin
                lo_d     = '0;
                hi_d     = $signed({1'b0, cnt_m1});
                mid_d    = init_mid;
                key_d    = operand_i;
                mem_re_o = 1'b1;
                state_d  = StSrch;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StSrch: begin
        if (hit) begin
          found_d = 1'b1;
          pos_d   = pos_ext[PosW-1:0];
          state_d = StDone;
        end else if (go_up) begin
          lo_d        = a_lo;
          mid_d       = a_mid;
          mem_raddr_o = AW'(cnt_m1 - a_mid);
          mem_re_o    = a_cont;
          if (!a_cont) begin
            state_d = StDone;
          end
        end else begin
          hi_d        = b_hi;
          mid_d       = b_mid;
          mem_raddr_o = AW'(cnt_m1 - b_mid);
          mem_re_o    = b_cont;
          if (!b_cont) begin
            state_d = StDone;
          end
        end
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // search window and pending result
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    key_q   <= key_d;
    stat_q  <= stat_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  // result beat towards the output stage; count is already settled here
  assign res_valid_o       = (state_q == StDone);
  assign res_o.status      = stat_q;
  assign res_o.found       = found_q;
  assign res_o.position    = pos_q;
  assign res_o.item_count  = cnt_ext[CountW-1:0];

  `SSS_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= DepthC, "count above depth")
  `SSS_ASSERT_ALWAYS(a_port_excl, clk_i, rst_ni, !(mem_we_o && mem_re_o), "read and write together")
  `SSS_ASSERT_IMP(a_srch_window, clk_i, rst_ni, state_q == StSrch, lo_q <= hi_q, "empty window probed")
  `SSS_ASSERT_NXT(a_push_count, clk_i, rst_ni, mem_we_o, count_q == $past(count_q) + CW'(1), "push count")
  `SSS_ASSERT_NXT(a_srch_hold, clk_i, rst_ni, state_q == StSrch, $stable(count_q), "count moved in search")

endmodule

[src/sorted_stack_binary_search.sv]
// Top level of the sorted stack with push, pop and binary search
//
//  channel  | dir | tdata                     | tuser
//  ---------+-----+---------------------------+---------------
//  s_axis   | in  | operand_value[31:0]       | command[1:0]
//  m_axis   | out | found, position, count    | status[1:0]
//
// Push, pop and unused codes go straight from idle to done in the sequencer.
// A search also walks through the search state, with one memory read per probe;
// the number of probes is at most floor(log2(count)) + 1 (9 at 256 entries).
// A result passes from the sequencer's done state into the m_axis output register;
// the next command is taken while it waits there. Output stalls hold the sequencer
// only once that register is full. Reset clears the count; the store is not cleared.
`timescale 1ns / 1ps

module sorted_stack_binary_search
  import sss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ValW-1:0]     s_axis_tdata,   // [31:0] operand_value
  input  logic [CmdW-1:0]     s_axis_tuser,   // [1:0] command
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [0] found, [8:1] position, [17:9] item_count
  output logic [StatW-1:0]    m_axis_tuser    // [1:0] status
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [ValW-1:0] mem_wdata, mem_rdata;
  logic            res_valid, res_ready;
  res_t            res;
  logic            out_valid_q, out_valid_d;
  res_t            out_res_q;

  sss_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .operand_i   ($signed(s_axis_tdata)),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sss_mem #(
    .Depth (STACK_DEPTH),
    .AddrW (AW),
    .DataW (ValW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready   = !out_valid_q || m_axis_tready;
  assign out_valid_d = res_valid || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  // beat packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, out_res_q.item_count,
                          out_res_q.position, out_res_q.found};
  assign m_axis_tuser  = out_res_q.status;

endmodule

[test/sss_result_checker.sv]
// Result checker for the sorted stack search block: tracks the stack, predicts each result
`timescale 1ns / 1ps

module sss_result_checker
  import sss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [ValW-1:0]     s_axis_tdata,   // [31:0] operand_value
  input  logic [CmdW-1:0]     s_axis_tuser,   // [1:0] command
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // [0] found, [8:1] position, [17:9] item_count
  input  logic [StatW-1:0]    m_axis_tuser,   // [1:0] status
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_results_o
);

  // Own copy of the stack, indexed from the bottom
  logic [ValW-1:0] stack_mem [STACK_DEPTH];
  int unsigned     stack_fill;
  res_t            expected_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    mismatch_count_o++;
  endtask

  task automatic check_field(input string field, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
    end
  endtask

  // Apply one command to the stack copy and work out the result it gives
  function automatic res_t apply_command(input logic [CmdW-1:0] cmd,
                                         input logic [ValW-1:0] operand);
    res_t            res;
    int              lo;
    int              hi;
    int              mid;
    logic [ValW-1:0] probe;
    res        = '0;
    res.status = STAT_OK;
    case (cmd)
      CMD_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          stack_mem[stack_fill] = operand;
          stack_fill++;
        end
      end
      CMD_POP: begin
        if (stack_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          stack_fill--;
        end
      end
      CMD_SEARCH: begin
        // positions count from the top; the walk is the same for unsorted contents
        lo = 0;
        hi = int'(stack_fill) - 1;
        while (lo <= hi && !res.found) begin
          mid   = (lo + hi) / 2;
          probe = stack_mem[stack_fill - 1 - mid];
          if ($signed(probe) == $signed(operand)) begin
            res.found    = 1'b1;
            res.position = mid[PosW-1:0];
          end else if ($signed(probe) < $signed(operand)) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
      default: ;  // unused code: no change
    endcase
    res.item_count = stack_fill[CountW-1:0];
    return res;
  endfunction

  // Result beats are checked before command beats of the same edge are taken
  always @(posedge clk_i or negedge rst_ni) begin : watch_beats
    res_t want;
    if (!rst_ni) begin
      stack_fill = 0;
      expected_q.delete();
      pending_results_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with no command outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("status", m_axis_tuser, want.status);
          check_field("found", m_axis_tdata[0], want.found);
          check_field("position", m_axis_tdata[PosW:1], want.position);
          check_field("item_count", m_axis_tdata[PosW+CountW:PosW+1], want.item_count);
          check_field("tdata padding", m_axis_tdata[OutDataW-1:PosW+CountW+1], 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(apply_command(s_axis_tuser, s_axis_tdata));
      end
      pending_results_o = expected_q.size();
    end
  end

endmodule

[test/tb_top.sv]
// Testbench top for the sorted stack search block: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_top;
  import sss_pkg::*;

  localparam int unsigned Depth       = 256;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned TailCycles  = 40;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam logic [ValW-1:0] MaxVal    = 32'h7fff_ffff;
  localparam logic [ValW-1:0] MinVal    = 32'h8000_0000;
  localparam longint          MinLong   = -64'sd2147483648;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ValW-1:0]     s_axis_tdata  = '0;
  logic [CmdW-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatW-1:0]    m_axis_tuser;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  logic        stalled_out = 1'b0;
  logic        quiet_mode  = 1'b0;
  int unsigned ready_run   = 0;
  int unsigned issued      = 0;

  // Stack contents as seen by the stimulus, bottom first; used to pick keys
  logic [ValW-1:0] stack_view [$];

  sorted_stack_binary_search #(
    .STACK_DEPTH (Depth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  sss_result_checker #(
    .STACK_DEPTH (Depth)
  ) i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .mismatch_count_o  (mismatches),
    .pending_results_o (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: cycles without any beat on either side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
      stalled_out <= 1'b0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        stalled_out <= 1'b1;
      end
    end
  end

  // Result side back-pressure: runs of ready and stall, mostly short
  always @(posedge clk_i) begin : ready_gen
    int unsigned pick;
    if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (quiet_mode || pick < 55) begin
        m_axis_tready <= 1'b1;
        ready_run     <= $urandom_range(0, 6);
      end else if (pick < 95) begin
        m_axis_tready <= 1'b0;
        ready_run     <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_run     <= $urandom_range(10, 50);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (quiet_mode || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drive one command beat; returns at the edge where it is taken
  task automatic send_beat(input logic [CmdW-1:0] cmd, input logic [ValW-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic issue(input logic [CmdW-1:0] cmd, input logic [ValW-1:0] val);
    send_beat(cmd, val);
    case (cmd)
      CMD_PUSH: if (stack_view.size() < Depth) stack_view.push_back(val);
      CMD_POP:  if (stack_view.size() > 0) void'(stack_view.pop_back());
      default:  ;
    endcase
    if (cmd != CmdUnused) issued++;
  endtask

  // A value at or below the given one, clamped at the most negative value
  function automatic logic [ValW-1:0] value_below(input logic [ValW-1:0] upper,
                                                  input int unsigned max_step);
    longint cand;
    cand = longint'($signed(upper)) - longint'($urandom_range(0, max_step));
    if (cand < MinLong) cand = MinLong;
    return cand[ValW-1:0];
  endfunction

  // Mostly keys that are stored, some neighbours and some random ones
  function automatic logic [ValW-1:0] search_key();
    int unsigned     pick;
    logic [ValW-1:0] hit;
    pick = $urandom_range(0, 7);
    if (stack_view.size() == 0 || pick == 0) return $urandom();
    hit = stack_view[$urandom_range(0, stack_view.size() - 1)];
    if (pick == 1) return hit + 1;
    if (pick == 2) return hit - 1;
    return hit;
  endfunction

  task automatic run_directed();
    // empty stack cases
    issue(CMD_POP, '0);
    issue(CMD_SEARCH, '0);
    issue(CmdUnused, 32'hffff_ffff);
    // ascending from the top: smallest value pushed last
    issue(CMD_PUSH, MaxVal);
    issue(CMD_PUSH, 32'd1);
    issue(CMD_PUSH, 32'd0);
    issue(CMD_PUSH, 32'hffff_ffff);
    issue(CMD_PUSH, MinVal);
    issue(CMD_SEARCH, MinVal);
    issue(CMD_SEARCH, MaxVal);
    issue(CMD_SEARCH, 32'd0);
    issue(CMD_SEARCH, 32'd5);
    issue(CMD_SEARCH, 32'hffff_fffe);
    issue(CmdUnused, '0);
    issue(CMD_POP, '0);
    issue(CMD_SEARCH, MinVal);
    // order broken at the top
    issue(CMD_PUSH, 32'd100);
    issue(CMD_SEARCH, 32'd100);
    issue(CMD_SEARCH, 32'hffff_ffff);
    repeat (6) issue(CMD_POP, 32'h5a5a_a5a5);
  endtask

  // Well-formed run: trim the stack, push a sorted batch, then search it
  task automatic run_sorted_block();
    int unsigned     keep;
    logic [ValW-1:0] val;
    keep = $urandom_range(0, 3);
    while (stack_view.size() > keep) issue(CMD_POP, $urandom());
    repeat ($urandom_range(1, 24)) begin
      if (stack_view.size() == 0) begin
        val = ($urandom_range(0, 3) == 0) ? MaxVal : $urandom();
      end else begin
        val = value_below(stack_view[$], ($urandom_range(0, 3) == 0) ? 2 : 32'h0fff_ffff);
      end
      issue(CMD_PUSH, val);
    end
    if ($urandom_range(0, 9) == 0) issue(CMD_PUSH, $urandom());
    repeat ($urandom_range(2, 8)) issue(CMD_SEARCH, search_key());
  endtask

  task automatic run_noise();
    repeat ($urandom_range(5, 15)) issue(CmdW'($urandom()), $urandom());
  endtask

  // Fill to the brim with sorted values, overflow, search deep, then drain past empty
  task automatic run_fill();
    while (stack_view.size() > 0) issue(CMD_POP, $urandom());
    issue(CMD_PUSH, MaxVal);
    while (stack_view.size() < Depth) issue(CMD_PUSH, value_below(stack_view[$], 32'h007f_ffff));
    repeat (3) issue(CMD_PUSH, $urandom());
    repeat (12) issue(CMD_SEARCH, search_key());
    repeat (Depth + 2) issue(CMD_POP, $urandom());
  endtask

  task automatic run_random();
    bit fill_done;
    fill_done = 1'b0;
    issued    = 0;
    while (issued < RandomItems) begin
      quiet_mode <= ($urandom_range(0, 5) == 0);
      if (!fill_done && issued >= 150) begin
        run_fill();
        fill_done = 1'b1;
      end else if ($urandom_range(0, 9) < 7) begin
        run_sorted_block();
      end else begin
        run_noise();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        // let the checker log the last command beat before polling its count
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        repeat (TailCycles) @(posedge clk_i);
      end
      wait (stalled_out);
    join_any
    if (!stalled_out && mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/sss_pkg.sv
src/sss_mem.sv
src/sss_seq.sv
src/sorted_stack_binary_search.sv
test/sss_result_checker.sv
test/tb_top.sv
